// File: hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the RTL of the matrix scan block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rmfb_pkg.sv
// ============================================================================
// rmfb_pkg
// Types and fixed constants shared by the matrix frame buffer scan modules.
// ============================================================================
`default_nettype none

package rmfb_pkg;

    localparam int NUM_PLANES  = 3;
    localparam int DATA_W      = 64;
    localparam int MODE_W      = 3;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 3;
    localparam int PLANE_SEL_W = 2;
    localparam int SCAN_ROW_W  = 5;
    localparam int BIT_POS_W   = 6;
    localparam int DWELL_W     = 16;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd150;

    // Plane order inside a stored row word.
    localparam int PLANE_RED   = 0;
    localparam int PLANE_GREEN = 1;
    localparam int PLANE_BLUE  = 2;

    // Bits of the colour mask.
    localparam int COLOR_BLUE_BIT  = 0;
    localparam int COLOR_GREEN_BIT = 1;
    localparam int COLOR_RED_BIT   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_PIXEL   = 3'd0,
        MODE_CLEAR_PIXEL = 3'd1,
        MODE_ROW_WRITE   = 3'd2,
        MODE_RAW_WRITE   = 3'd3,
        MODE_CLEAR_FRAME = 3'd4,
        MODE_SCAN_TICK   = 3'd5
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Current scan position and what the next tick will report.
    typedef struct packed {
        logic [SCAN_ROW_W-1:0] scan_row;
        logic [BIT_POS_W-1:0]  bit_pos;
        logic                  lit;
        logic                  first_lit;
        logic                  frame_end;
    } scan_pos_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmfb_store.sv
// ============================================================================
// rmfb_store
// Frame buffer: one row per word, three colour planes side by side, two
// registered read ports, one plane-masked write port and per-plane valid bits.
// ============================================================================
`default_nettype none

module rmfb_store #(
    parameter int PANEL_ROWS    = 64,
    parameter int PANEL_COLUMNS = 64
) (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  wire                                           rd_en,
    input  wire  [$clog2(PANEL_ROWS)-1:0]                 rd_addr_a,
    input  wire  [$clog2(PANEL_ROWS)-1:0]                 rd_addr_b,
    output logic [rmfb_pkg::NUM_PLANES*PANEL_COLUMNS-1:0] rd_data_a,
    output logic [rmfb_pkg::NUM_PLANES*PANEL_COLUMNS-1:0] rd_data_b,
    input  wire                                           wr_en,
    input  wire  [$clog2(PANEL_ROWS)-1:0]                 wr_addr,
    input  wire  [rmfb_pkg::NUM_PLANES-1:0]               wr_plane_mask,
    input  wire  [rmfb_pkg::NUM_PLANES*PANEL_COLUMNS-1:0] wr_data,
    input  wire                                           clr_all
);

    localparam int WORD_W = rmfb_pkg::NUM_PLANES * PANEL_COLUMNS;

    logic [WORD_W-1:0]               mem_reg [PANEL_ROWS];
    logic [rmfb_pkg::NUM_PLANES-1:0] vld_reg [PANEL_ROWS];
    logic [WORD_W-1:0]               rd_word_a_reg;
    logic [WORD_W-1:0]               rd_word_b_reg;
    logic [rmfb_pkg::NUM_PLANES-1:0] rd_vld_a_reg;
    logic [rmfb_pkg::NUM_PLANES-1:0] rd_vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int p = 0; p < rmfb_pkg::NUM_PLANES; p++)
            begin
                if (wr_plane_mask[p])
                begin
                    mem_reg[wr_addr][p*PANEL_COLUMNS +: PANEL_COLUMNS] <=
                        wr_data[p*PANEL_COLUMNS +: PANEL_COLUMNS];
                end
            end
        end
        if (rd_en)
        begin
            rd_word_a_reg <= mem_reg[rd_addr_a];
            rd_word_b_reg <= mem_reg[rd_addr_b];
        end
    end

    // A plane that was never written since reset or the last frame clear
    // reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < PANEL_ROWS; r++)
            begin
                vld_reg[r] <= '0;
            end
            rd_vld_a_reg <= '0;
            rd_vld_b_reg <= '0;
        end
        else
        begin
            if (clr_all)
            begin
                for (int r = 0; r < PANEL_ROWS; r++)
                begin
                    vld_reg[r] <= '0;
                end
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= vld_reg[wr_addr] | wr_plane_mask;
            end
            if (rd_en)
            begin
                rd_vld_a_reg <= vld_reg[rd_addr_a];
                rd_vld_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < rmfb_pkg::NUM_PLANES; p++)
        begin
            rd_data_a[p*PANEL_COLUMNS +: PANEL_COLUMNS] =
                rd_word_a_reg[p*PANEL_COLUMNS +: PANEL_COLUMNS] &
                {PANEL_COLUMNS{rd_vld_a_reg[p]}};
            rd_data_b[p*PANEL_COLUMNS +: PANEL_COLUMNS] =
                rd_word_b_reg[p*PANEL_COLUMNS +: PANEL_COLUMNS] &
                {PANEL_COLUMNS{rd_vld_b_reg[p]}};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmfb_scan.sv
// ============================================================================
// rmfb_scan
// Scan sequencer: column shift counter, lit dwell counter and row pair index.
// ============================================================================
`default_nettype none

module rmfb_scan #(
    parameter int PANEL_COLUMNS = 64,
    parameter int SCAN_PAIRS    = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                advance,
    input  wire  [rmfb_pkg::DWELL_W-1:0]       dwell_ticks,
    output rmfb_pkg::scan_pos_t                pos
);

    logic [rmfb_pkg::SCAN_ROW_W-1:0] scan_row_reg, scan_row_next;
    logic [rmfb_pkg::BIT_POS_W-1:0]  bit_pos_reg, bit_pos_next;
    logic                            lit_reg, lit_next;
    logic [rmfb_pkg::DWELL_W-1:0]    dwell_count_reg, dwell_count_next;

    logic [rmfb_pkg::DWELL_W-1:0]    count_inc;
    logic [rmfb_pkg::DWELL_W-1:0]    limit;
    logic                            lit_end;
    logic                            last_pair;

    always_comb
    begin
        count_inc = dwell_count_reg + 1'b1;
        limit     = (dwell_ticks == '0) ? rmfb_pkg::DWELL_W'(1) : dwell_ticks;
        lit_end   = (count_inc == '0) || (count_inc >= limit);
        last_pair = ({1'b0, scan_row_reg} + 1'b1) >= (rmfb_pkg::SCAN_ROW_W+1)'(SCAN_PAIRS);

        pos.scan_row  = scan_row_reg;
        pos.bit_pos   = bit_pos_reg;
        pos.lit       = lit_reg;
        pos.first_lit = lit_reg && (dwell_count_reg == '0);
        pos.frame_end = lit_reg && lit_end && last_pair;
    end

    always_comb
    begin
        scan_row_next    = scan_row_reg;
        bit_pos_next     = bit_pos_reg;
        lit_next         = lit_reg;
        dwell_count_next = dwell_count_reg;
        if (advance)
        begin
            if (!lit_reg)
            begin
                if (bit_pos_reg == '0)
                begin
                    lit_next         = 1'b1;
                    dwell_count_next = '0;
                end
                else
                begin
                    bit_pos_next = bit_pos_reg - 1'b1;
                end
            end
            else if (lit_end)
            begin
                scan_row_next    = last_pair ? '0 : scan_row_reg + 1'b1;
                lit_next         = 1'b0;
                dwell_count_next = '0;
                bit_pos_next     = rmfb_pkg::BIT_POS_W'(PANEL_COLUMNS - 1);
            end
            else
            begin
                dwell_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg    <= '0;
            bit_pos_reg     <= rmfb_pkg::BIT_POS_W'(PANEL_COLUMNS - 1);
            lit_reg         <= 1'b0;
            dwell_count_reg <= '0;
        end
        else
        begin
            scan_row_reg    <= scan_row_next;
            bit_pos_reg     <= bit_pos_next;
            lit_reg         <= lit_next;
            dwell_count_reg <= dwell_count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_matrix_framebuffer_scan.sv
// ============================================================================
// rgb_matrix_framebuffer_scan
// Frame buffer and row pair scan driver for a one-bit-per-colour LED matrix.
// ============================================================================
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  ------------------------------------
//  in        in_valid / in_ready            mode, row, column, color, plane,
//                                           row_data
//  out       out_valid / out_ready          six data bits, row_address,
//                                           shift_clock, latch_strobe, blank_n,
//                                           frame_done
//  cfg       cfg_write_enable               cfg_write_data (dwell_ticks)
//
//  Every item passes through two states: the accept in IDLE issues the frame
//  buffer read, and EXEC modifies and writes the row back, so one item is in flight
//  at a time and the read of the next item always sees the previous write.
//  A frame clear goes through the same two states; it drops the per-plane valid bits.
//  A scan tick holds in EXEC while the output register is full.
//  Reset clears the buffer valid bits, the scan position and the output beat.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module rgb_matrix_framebuffer_scan #(
    parameter int PANEL_ROWS    = 64,
    parameter int PANEL_COLUMNS = 64,
    parameter int SCAN_PAIRS    = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [rmfb_pkg::MODE_W-1:0]         mode,
    input  wire  [rmfb_pkg::COORD_W-1:0]        row,
    input  wire  [rmfb_pkg::COORD_W-1:0]        column,
    input  wire  [rmfb_pkg::COLOR_W-1:0]        color,
    input  wire  [rmfb_pkg::PLANE_SEL_W-1:0]    plane,
    input  wire  [rmfb_pkg::DATA_W-1:0]         row_data,

    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                red_top,
    output logic                                green_top,
    output logic                                blue_top,
    output logic                                red_bottom,
    output logic                                green_bottom,
    output logic                                blue_bottom,
    output logic [rmfb_pkg::SCAN_ROW_W-1:0]     row_address,
    output logic                                shift_clock,
    output logic                                latch_strobe,
    output logic                                blank_n,
    output logic                                frame_done,

    input  wire                                 cfg_write_enable,
    input  wire  [rmfb_pkg::DWELL_W-1:0]        cfg_write_data
);

    localparam int ROW_W  = $clog2(PANEL_ROWS);
    localparam int COL_W  = $clog2(PANEL_COLUMNS);
    localparam int WORD_W = rmfb_pkg::NUM_PLANES * PANEL_COLUMNS;
    localparam int CMP_W  = rmfb_pkg::COORD_W + 1;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [rmfb_pkg::DWELL_W-1:0] dwell_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= rmfb_pkg::DWELL_RESET;
        end
        else if (cfg_write_enable)
        begin
            dwell_ticks_reg <= cfg_write_data;
        end
    end

    // ------------------------------------------------------------------
    // Control state and the captured item.
    // ------------------------------------------------------------------
    rmfb_pkg::state_t state_reg, state_next;

    rmfb_pkg::mode_t                 mode_reg;
    logic [rmfb_pkg::COORD_W-1:0]    row_reg;
    logic [rmfb_pkg::COORD_W-1:0]    column_reg;
    logic [rmfb_pkg::COLOR_W-1:0]    color_reg;
    logic [rmfb_pkg::PLANE_SEL_W-1:0] plane_reg;
    logic [rmfb_pkg::DATA_W-1:0]     row_data_reg;

    logic                            accept;
    logic                            out_free;
    logic                            is_scan;
    logic                            scan_advance;
    logic                            rd_en;

    rmfb_pkg::scan_pos_t             pos;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;
    assign is_scan  = (mode_reg == rmfb_pkg::MODE_SCAN_TICK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmfb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rmfb_pkg::ST_EXEC;
                end
            end
            rmfb_pkg::ST_EXEC:
            begin
                if (!is_scan || out_free)
                begin
                    state_next = rmfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        rd_en        = 1'b0;
        scan_advance = 1'b0;
        unique case (state_reg)
            rmfb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            rmfb_pkg::ST_EXEC:
            begin
                scan_advance = is_scan && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmfb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= rmfb_pkg::mode_t'(mode);
            row_reg      <= row;
            column_reg   <= column;
            color_reg    <= color;
            plane_reg    <= plane;
            row_data_reg <= row_data;
        end
    end

    // ------------------------------------------------------------------
    // Read addresses. A scan tick reads the top row and its partner row
    // SCAN_PAIRS further down; write modes read the addressed row.
    // Rows past the panel are read anyway and masked off below.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] top_sum;
    logic [CMP_W-1:0] bot_sum;
    logic             top_ok;
    logic             bot_ok;
    logic [ROW_W-1:0] rd_addr_a;
    logic [ROW_W-1:0] rd_addr_b;

    always_comb
    begin
        top_sum   = CMP_W'(pos.scan_row);
        bot_sum   = CMP_W'(pos.scan_row) + CMP_W'(SCAN_PAIRS);
        top_ok    = top_sum < CMP_W'(PANEL_ROWS);
        bot_ok    = bot_sum < CMP_W'(PANEL_ROWS);
        rd_addr_a = (mode == rmfb_pkg::MODE_SCAN_TICK) ? top_sum[ROW_W-1:0] : row[ROW_W-1:0];
        rd_addr_b = bot_sum[ROW_W-1:0];
    end

    // ------------------------------------------------------------------
    // Modify and write back.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]               rd_data_a;
    logic [WORD_W-1:0]               rd_data_b;
    logic                            wr_en;
    logic [rmfb_pkg::NUM_PLANES-1:0] wr_plane_mask;
    logic [WORD_W-1:0]               wr_data;
    logic                            clr_all;

    logic                            row_ok;
    logic                            col_ok;
    logic [PANEL_COLUMNS-1:0]        col_bit;
    logic [rmfb_pkg::NUM_PLANES-1:0] color_planes;
    logic [rmfb_pkg::NUM_PLANES-1:0] raw_plane;

    always_comb
    begin
        row_ok  = CMP_W'(row_reg) < CMP_W'(PANEL_ROWS);
        col_ok  = CMP_W'(column_reg) < CMP_W'(PANEL_COLUMNS);
        col_bit = PANEL_COLUMNS'(1) << column_reg[COL_W-1:0];

        // The colour mask lists planes blue first; the row word lists red first.
        color_planes = '0;
        color_planes[rmfb_pkg::PLANE_RED]   = color_reg[rmfb_pkg::COLOR_RED_BIT];
        color_planes[rmfb_pkg::PLANE_GREEN] = color_reg[rmfb_pkg::COLOR_GREEN_BIT];
        color_planes[rmfb_pkg::PLANE_BLUE]  = color_reg[rmfb_pkg::COLOR_BLUE_BIT];

        raw_plane = '0;
        if (CMP_W'(plane_reg) < CMP_W'(rmfb_pkg::NUM_PLANES))
        begin
            raw_plane[plane_reg] = 1'b1;
        end

        wr_plane_mask = '0;
        wr_data       = {rmfb_pkg::NUM_PLANES{row_data_reg[PANEL_COLUMNS-1:0]}};
        clr_all       = 1'b0;
        unique case (mode_reg)
            rmfb_pkg::MODE_SET_PIXEL:
            begin
                wr_data = rd_data_a | {rmfb_pkg::NUM_PLANES{col_bit}};
                if (row_ok && col_ok)
                begin
                    wr_plane_mask = color_planes;
                end
            end
            rmfb_pkg::MODE_CLEAR_PIXEL:
            begin
                wr_data = rd_data_a & ~{rmfb_pkg::NUM_PLANES{col_bit}};
                if (row_ok && col_ok)
                begin
                    wr_plane_mask = '1;
                end
            end
            rmfb_pkg::MODE_ROW_WRITE:
            begin
                if (row_ok)
                begin
                    wr_plane_mask = color_planes;
                end
            end
            rmfb_pkg::MODE_RAW_WRITE:
            begin
                if (row_ok)
                begin
                    wr_plane_mask = raw_plane;
                end
            end
            rmfb_pkg::MODE_CLEAR_FRAME:
            begin
                clr_all = 1'b1;
            end
            default:
            begin
                wr_plane_mask = '0;
            end
        endcase

        wr_en = (state_reg == rmfb_pkg::ST_EXEC) && (wr_plane_mask != '0);
        if (state_reg != rmfb_pkg::ST_EXEC)
        begin
            clr_all = 1'b0;
        end
    end

    rmfb_store #(
        .PANEL_ROWS    (PANEL_ROWS),
        .PANEL_COLUMNS (PANEL_COLUMNS)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_en         (rd_en),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b),
        .wr_en         (wr_en),
        .wr_addr       (row_reg[ROW_W-1:0]),
        .wr_plane_mask (wr_plane_mask),
        .wr_data       (wr_data),
        .clr_all       (clr_all)
    );

    rmfb_scan #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_PAIRS    (SCAN_PAIRS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (scan_advance),
        .dwell_ticks (dwell_ticks_reg),
        .pos         (pos)
    );

    // ------------------------------------------------------------------
    // Pin snapshot. Data bits are only driven while shifting; a row that
    // lies past the panel shifts out zeros.
    // ------------------------------------------------------------------
    logic [rmfb_pkg::NUM_PLANES-1:0] top_bits;
    logic [rmfb_pkg::NUM_PLANES-1:0] bot_bits;

    always_comb
    begin
        for (int p = 0; p < rmfb_pkg::NUM_PLANES; p++)
        begin
            top_bits[p] = rd_data_a[p*PANEL_COLUMNS + int'(pos.bit_pos[COL_W-1:0])] &&
                          top_ok && !pos.lit;
            bot_bits[p] = rd_data_b[p*PANEL_COLUMNS + int'(pos.bit_pos[COL_W-1:0])] &&
                          bot_ok && !pos.lit;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                            out_valid_reg;
    logic [rmfb_pkg::NUM_PLANES-1:0] top_bits_reg;
    logic [rmfb_pkg::NUM_PLANES-1:0] bot_bits_reg;
    logic [rmfb_pkg::SCAN_ROW_W-1:0] row_address_reg;
    logic                            shift_clock_reg;
    logic                            latch_strobe_reg;
    logic                            blank_n_reg;
    logic                            frame_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (scan_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_advance)
        begin
            top_bits_reg     <= top_bits;
            bot_bits_reg     <= bot_bits;
            row_address_reg  <= pos.scan_row;
            shift_clock_reg  <= !pos.lit;
            latch_strobe_reg <= pos.first_lit;
            blank_n_reg      <= !pos.lit;
            frame_done_reg   <= pos.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_top      = top_bits_reg[rmfb_pkg::PLANE_RED];
    assign green_top    = top_bits_reg[rmfb_pkg::PLANE_GREEN];
    assign blue_top     = top_bits_reg[rmfb_pkg::PLANE_BLUE];
    assign red_bottom   = bot_bits_reg[rmfb_pkg::PLANE_RED];
    assign green_bottom = bot_bits_reg[rmfb_pkg::PLANE_GREEN];
    assign blue_bottom  = bot_bits_reg[rmfb_pkg::PLANE_BLUE];
    assign row_address  = row_address_reg;
    assign shift_clock  = shift_clock_reg;
    assign latch_strobe = latch_strobe_reg;
    assign blank_n      = blank_n_reg;
    assign frame_done   = frame_done_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, accept, !in_ready,
        "a second item was accepted before the write-back finished")

    `ASSERT_IMPLIES(a_lit_data_dark, clk, rst_n, out_valid && !blank_n,
        !(red_top || green_top || blue_top || red_bottom || green_bottom || blue_bottom),
        "data bits driven while the row pair is lit")

    `ASSERT_IMPLIES(a_latch_when_lit, clk, rst_n, out_valid && latch_strobe,
        !blank_n && !shift_clock,
        "latch strobe outside the lit phase")

    `ASSERT_IMPLIES(a_frame_done_last_pair, clk, rst_n, out_valid && frame_done,
        !blank_n && (row_address == rmfb_pkg::SCAN_ROW_W'(SCAN_PAIRS - 1)),
        "frame done flagged away from the last row pair")

endmodule

`default_nettype wire

// File: sim/rgb_matrix_framebuffer_scan_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// rgb_matrix_framebuffer_scan_tb
// Self-checking bench for the LED matrix frame buffer and row pair scan
// driver. A queue of commands feeds a randomly pausing driver, while a
// shadow frame buffer and scan position predict every output beat. The
// output side stalls at random. Beats are compared field by field in order,
// and the run walks several dwell settings, including both extremes.
// ============================================================================

module rgb_matrix_framebuffer_scan_tb;

    // Panel geometry; the block is built with its default sizes.
    localparam int PANEL_ROWS    = 64;
    localparam int PANEL_COLUMNS = 64;
    localparam int SCAN_PAIRS    = 32;

    // Mode codes that the block ignores, and the plane code that names no plane.
    localparam logic [rmfb_pkg::MODE_W-1:0]      MODE_SPARE_LO = 3'd6;
    localparam logic [rmfb_pkg::MODE_W-1:0]      MODE_SPARE_HI = 3'd7;
    localparam logic [rmfb_pkg::PLANE_SEL_W-1:0] PLANE_NONE    = 2'd3;

    // Cycles to let the item pipeline empty before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // The receiver holds off this long once, after this many output beats.
    localparam int HOLD_OFF_AT   = 300;
    localparam int HOLD_OFF_LEN  = 80;

    typedef struct {
        logic [rmfb_pkg::MODE_W-1:0]      mode;
        logic [rmfb_pkg::COORD_W-1:0]     row;
        logic [rmfb_pkg::COORD_W-1:0]     column;
        logic [rmfb_pkg::COLOR_W-1:0]     color;
        logic [rmfb_pkg::PLANE_SEL_W-1:0] plane;
        logic [rmfb_pkg::DATA_W-1:0]      row_data;
        bit                               hold_for_drain;
    } panel_cmd_t;

    typedef struct {
        logic                            red_top;
        logic                            green_top;
        logic                            blue_top;
        logic                            red_bottom;
        logic                            green_bottom;
        logic                            blue_bottom;
        logic [rmfb_pkg::SCAN_ROW_W-1:0] row_address;
        logic                            shift_clock;
        logic                            latch_strobe;
        logic                            blank_n;
        logic                            frame_done;
    } pin_beat_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [rmfb_pkg::MODE_W-1:0]      mode     = '0;
    logic [rmfb_pkg::COORD_W-1:0]     row      = '0;
    logic [rmfb_pkg::COORD_W-1:0]     column   = '0;
    logic [rmfb_pkg::COLOR_W-1:0]     color    = '0;
    logic [rmfb_pkg::PLANE_SEL_W-1:0] plane    = '0;
    logic [rmfb_pkg::DATA_W-1:0]      row_data = '0;

    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             red_top;
    logic                             green_top;
    logic                             blue_top;
    logic                             red_bottom;
    logic                             green_bottom;
    logic                             blue_bottom;
    logic [rmfb_pkg::SCAN_ROW_W-1:0]  row_address;
    logic                             shift_clock;
    logic                             latch_strobe;
    logic                             blank_n;
    logic                             frame_done;

    logic                             cfg_write_enable = 1'b0;
    logic [rmfb_pkg::DWELL_W-1:0]     cfg_write_data   = '0;

    rgb_matrix_framebuffer_scan #(
        .PANEL_ROWS    (PANEL_ROWS),
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_PAIRS    (SCAN_PAIRS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .row              (row),
        .column           (column),
        .color            (color),
        .plane            (plane),
        .row_data         (row_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .red_top          (red_top),
        .green_top        (green_top),
        .blue_top         (blue_top),
        .red_bottom       (red_bottom),
        .green_bottom     (green_bottom),
        .blue_bottom      (blue_bottom),
        .row_address      (row_address),
        .shift_clock      (shift_clock),
        .latch_strobe     (latch_strobe),
        .blank_n          (blank_n),
        .frame_done       (frame_done),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Shadow of the block: frame buffer planes, scan position and dwell.
    // ------------------------------------------------------------------------
    logic [rmfb_pkg::DATA_W-1:0]     shadow_fb [0:PANEL_ROWS-1][0:rmfb_pkg::NUM_PLANES-1];
    logic [rmfb_pkg::SCAN_ROW_W-1:0] shadow_scan_row;
    logic [rmfb_pkg::BIT_POS_W-1:0]  shadow_bit_pos;
    bit                              shadow_lit;
    logic [rmfb_pkg::DWELL_W-1:0]    shadow_lit_ticks;
    logic [rmfb_pkg::DWELL_W-1:0]    shadow_dwell;

    // Queues: commands still to be offered, and pin beats still owed.
    panel_cmd_t cmd_backlog[$];
    pin_beat_t  pin_beats_due[$];

    int unsigned error_count  = 0;
    int unsigned beats_seen   = 0;
    int unsigned quiet_cycles = 0;

    // Handshake results of the last rising edge, read by the falling-edge
    // processes.
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;

    // Per-side pause bookkeeping.
    int unsigned tx_wait = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_hold = 0;

    task automatic blank_shadow_fb();
        for (int r = 0; r < PANEL_ROWS; r++)
        begin
            for (int p = 0; p < rmfb_pkg::NUM_PLANES; p++)
            begin
                shadow_fb[r][p] = '0;
            end
        end
    endtask

    // Writes the planes picked by a colour mask, either replacing the word or
    // OR-ing the bits in.
    task automatic paint_planes(input logic [rmfb_pkg::COORD_W-1:0] r,
                                input logic [rmfb_pkg::COLOR_W-1:0] mask,
                                input logic [rmfb_pkg::DATA_W-1:0] bits,
                                input bit replace);
        if (mask[rmfb_pkg::COLOR_BLUE_BIT])
            shadow_fb[r][rmfb_pkg::PLANE_BLUE] =
                replace ? bits : (shadow_fb[r][rmfb_pkg::PLANE_BLUE] | bits);
        if (mask[rmfb_pkg::COLOR_GREEN_BIT])
            shadow_fb[r][rmfb_pkg::PLANE_GREEN] =
                replace ? bits : (shadow_fb[r][rmfb_pkg::PLANE_GREEN] | bits);
        if (mask[rmfb_pkg::COLOR_RED_BIT])
            shadow_fb[r][rmfb_pkg::PLANE_RED] =
                replace ? bits : (shadow_fb[r][rmfb_pkg::PLANE_RED] | bits);
    endtask

    // Applies one accepted command to the shadow. A scan tick also queues
    // the pin beat it must produce.
    task automatic step_panel_shadow(input panel_cmd_t c);
        pin_beat_t   beat;
        int unsigned bottom;
        int unsigned dwell_limit;
        logic [rmfb_pkg::DATA_W-1:0] one_hot;

        beat    = '{default: '0};
        one_hot = {{(rmfb_pkg::DATA_W-1){1'b0}}, 1'b1} << c.column;
        case (c.mode)
            rmfb_pkg::MODE_SET_PIXEL:
                if (c.row < PANEL_ROWS && c.column < PANEL_COLUMNS)
                    paint_planes(c.row, c.color, one_hot, 1'b0);
            rmfb_pkg::MODE_CLEAR_PIXEL:
                if (c.row < PANEL_ROWS && c.column < PANEL_COLUMNS)
                begin
                    shadow_fb[c.row][rmfb_pkg::PLANE_RED]   &= ~one_hot;
                    shadow_fb[c.row][rmfb_pkg::PLANE_GREEN] &= ~one_hot;
                    shadow_fb[c.row][rmfb_pkg::PLANE_BLUE]  &= ~one_hot;
                end
            rmfb_pkg::MODE_ROW_WRITE:
                if (c.row < PANEL_ROWS)
                    paint_planes(c.row, c.color, c.row_data, 1'b1);
            rmfb_pkg::MODE_RAW_WRITE:
                if (c.row < PANEL_ROWS && c.plane != PLANE_NONE)
                    shadow_fb[c.row][c.plane] = c.row_data;
            rmfb_pkg::MODE_CLEAR_FRAME:
                blank_shadow_fb();
            rmfb_pkg::MODE_SCAN_TICK:
            begin
                beat.row_address = shadow_scan_row;
                if (!shadow_lit)
                begin
                    // Shifting: the panel is dark and one column goes out per tick.
                    bottom = shadow_scan_row + SCAN_PAIRS;
                    beat.red_top   =
                        shadow_fb[shadow_scan_row][rmfb_pkg::PLANE_RED][shadow_bit_pos];
                    beat.green_top =
                        shadow_fb[shadow_scan_row][rmfb_pkg::PLANE_GREEN][shadow_bit_pos];
                    beat.blue_top  =
                        shadow_fb[shadow_scan_row][rmfb_pkg::PLANE_BLUE][shadow_bit_pos];
                    if (bottom < PANEL_ROWS)
                    begin
                        beat.red_bottom   =
                            shadow_fb[bottom][rmfb_pkg::PLANE_RED][shadow_bit_pos];
                        beat.green_bottom =
                            shadow_fb[bottom][rmfb_pkg::PLANE_GREEN][shadow_bit_pos];
                        beat.blue_bottom  =
                            shadow_fb[bottom][rmfb_pkg::PLANE_BLUE][shadow_bit_pos];
                    end
                    beat.shift_clock = 1'b1;
                    beat.blank_n     = 1'b1;
                    if (shadow_bit_pos == 0)
                    begin
                        shadow_lit       = 1'b1;
                        shadow_lit_ticks = '0;
                    end
                    else
                    begin
                        shadow_bit_pos = shadow_bit_pos - 1'b1;
                    end
                end
                else
                begin
                    // Lit: latch on the first tick, then count out the dwell.
                    // A dwell of zero behaves as one, and a dwell lowered below
                    // the ticks already spent ends the row pair at once.
                    dwell_limit = (shadow_dwell == 0) ? 1 : shadow_dwell;
                    beat.latch_strobe = (shadow_lit_ticks == 0);
                    beat.blank_n      = 1'b0;
                    shadow_lit_ticks  = shadow_lit_ticks + 1'b1;
                    if (shadow_lit_ticks == 0 || shadow_lit_ticks >= dwell_limit)
                    begin
                        if (shadow_scan_row + 1 >= SCAN_PAIRS)
                        begin
                            beat.frame_done = 1'b1;
                            shadow_scan_row = '0;
                        end
                        else
                        begin
                            shadow_scan_row = shadow_scan_row + 1'b1;
                        end
                        shadow_lit       = 1'b0;
                        shadow_lit_ticks = '0;
                        shadow_bit_pos   = rmfb_pkg::BIT_POS_W'(PANEL_COLUMNS - 1);
                    end
                end
                pin_beats_due.push_back(beat);
            end
            default:
            begin
                // The spare mode codes leave everything as it is.
            end
        endcase
    endtask

    task automatic check_pin(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Command builders for the stimulus.
    // ------------------------------------------------------------------------
    function automatic panel_cmd_t make_cmd(input int unsigned m,
                                            input int unsigned r,
                                            input int unsigned col,
                                            input int unsigned mask,
                                            input int unsigned pl,
                                            input logic [rmfb_pkg::DATA_W-1:0] bits);
        panel_cmd_t c;
        c.mode           = rmfb_pkg::MODE_W'(m);
        c.row            = rmfb_pkg::COORD_W'(r);
        c.column         = rmfb_pkg::COORD_W'(col);
        c.color          = rmfb_pkg::COLOR_W'(mask);
        c.plane          = rmfb_pkg::PLANE_SEL_W'(pl);
        c.row_data       = bits;
        c.hold_for_drain = 1'b0;
        return c;
    endfunction

    // Random command; tick_pct is the share of scan ticks. Among the writes,
    // frame clears are kept rare so that the scan has pixels to show, and a
    // few commands are noise: spare modes and raw writes to no plane.
    function automatic panel_cmd_t random_cmd(input int unsigned tick_pct);
        panel_cmd_t  c;
        int unsigned pick;
        c = make_cmd(rmfb_pkg::MODE_SCAN_TICK, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 7), $urandom_range(0, 2), {$urandom, $urandom});
        if ($urandom_range(0, 9) == 0)
            c.plane = PLANE_NONE;
        if ($urandom_range(0, 99) >= tick_pct)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c.mode = rmfb_pkg::MODE_SET_PIXEL;
            else if (pick < 48)
                c.mode = rmfb_pkg::MODE_CLEAR_PIXEL;
            else if (pick < 72)
                c.mode = rmfb_pkg::MODE_ROW_WRITE;
            else if (pick < 95)
                c.mode = rmfb_pkg::MODE_RAW_WRITE;
            else if (pick < 96)
                c.mode = rmfb_pkg::MODE_CLEAR_FRAME;
            else
                c.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        end
        return c;
    endfunction

    // Random pause before the next beat on one side, with occasional
    // stretches where that side runs flat out.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm = $urandom_range(16, 48);
        return $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Works on the falling edge: holds a beat until it is taken, then
    // waits its drawn pause and offers the next command from the backlog. A
    // command marked hold_for_drain is not offered until every owed pin beat
    // has come out.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_taken)
                tx_wait = draw_wait(tx_calm);
            if (!in_valid || in_taken)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].hold_for_drain && pin_beats_due.size() != 0))
                begin
                    mode     <= cmd_backlog[0].mode;
                    row      <= cmd_backlog[0].row;
                    column   <= cmd_backlog[0].column;
                    color    <= cmd_backlog[0].color;
                    plane    <= cmd_backlog[0].plane;
                    row_data <= cmd_backlog[0].row_data;
                    in_valid <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Also on the falling edge: after each output beat it draws a
    // pause. Once, after HOLD_OFF_AT beats, it holds ready low for a long
    // stretch while the driver keeps offering, so the output register fills
    // and the input side backs up.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                rx_wait = draw_wait(rx_calm);
                if (beats_seen == HOLD_OFF_AT)
                    rx_hold = HOLD_OFF_LEN;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On the rising edge, every accepted input beat is run through
    // the shadow, and every accepted output beat is checked against the
    // oldest owed beat.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (in_valid && in_ready)
                step_panel_shadow(make_cmd(mode, row, column, color, plane, row_data));
            if (out_valid && out_ready)
            begin
                beats_seen++;
                if (pin_beats_due.size() == 0)
                begin
                    $error("output beat with no scan tick behind it");
                    error_count++;
                end
                else
                begin
                    check_pin("red_top",      pin_beats_due[0].red_top,      red_top);
                    check_pin("green_top",    pin_beats_due[0].green_top,    green_top);
                    check_pin("blue_top",     pin_beats_due[0].blue_top,     blue_top);
                    check_pin("red_bottom",   pin_beats_due[0].red_bottom,   red_bottom);
                    check_pin("green_bottom", pin_beats_due[0].green_bottom, green_bottom);
                    check_pin("blue_bottom",  pin_beats_due[0].blue_bottom,  blue_bottom);
                    check_pin("row_address",  pin_beats_due[0].row_address,  row_address);
                    check_pin("shift_clock",  pin_beats_due[0].shift_clock,  shift_clock);
                    check_pin("latch_strobe", pin_beats_due[0].latch_strobe, latch_strobe);
                    check_pin("blank_n",      pin_beats_due[0].blank_n,      blank_n);
                    check_pin("frame_done",   pin_beats_due[0].frame_done,   frame_done);
                    void'(pin_beats_due.pop_front());
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no beat on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------------

    // Waits until every command is taken and every owed beat has come, then
    // lets the last write-only command drain out of the pipeline.
    task automatic settle();
        while (cmd_backlog.size() != 0 || in_valid || pin_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dwell(input logic [rmfb_pkg::DWELL_W-1:0] ticks);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= ticks;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        shadow_dwell = ticks;
    endtask

    task automatic queue_random(input int unsigned count, input int unsigned tick_pct);
        for (int n = 0; n < count; n++)
            cmd_backlog.push_back(random_cmd(tick_pct));
    endtask

    initial
    begin
        panel_cmd_t c;

        blank_shadow_fb();
        shadow_scan_row  = '0;
        shadow_bit_pos   = rmfb_pkg::BIT_POS_W'(PANEL_COLUMNS - 1);
        shadow_lit       = 1'b0;
        shadow_lit_ticks = '0;
        shadow_dwell     = rmfb_pkg::DWELL_RESET;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset dwell. Row 0 and row 32 form the first
        // row pair, so the opening ticks show these writes on both halves.
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_RAW_WRITE, 0, 0, 0,
                                       rmfb_pkg::PLANE_RED, '1));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_RAW_WRITE, 0, 0, 0,
                                       rmfb_pkg::PLANE_GREEN, 64'h8000_0000_0000_0001));
        // A raw write to no plane must not disturb anything.
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_RAW_WRITE, 0, 0, 0, PLANE_NONE, '0));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_ROW_WRITE, 32, 0, 7, 0,
                                       64'hAAAA_AAAA_AAAA_AAAA));
        // A masked row write with an empty mask touches no plane.
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_ROW_WRITE, 33, 0, 0, 0, '1));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SET_PIXEL, 0, 63, 1, 0, '0));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SET_PIXEL, 63, 0, 7, 0, '0));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_CLEAR_PIXEL, 0, 62, 0, 0, '0));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_CLEAR_PIXEL, 32, 63, 0, 0, '0));
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SET_PIXEL, 32, 61, 2, 0, '0));
        cmd_backlog.push_back(make_cmd(MODE_SPARE_LO, 0, 0, 7, 0, '1));
        cmd_backlog.push_back(make_cmd(MODE_SPARE_HI, 63, 63, 7, PLANE_NONE, '1));
        for (int n = 0; n < 12; n++)
            cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SCAN_TICK, 0, 0, 0, 0, '0));
        // Clearing the frame keeps the scan position: the next ticks carry on
        // mid-row with dark data.
        cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_CLEAR_FRAME, 0, 0, 0, 0, '0));
        for (int n = 0; n < 3; n++)
            cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SCAN_TICK, 0, 0, 0, 0, '0));
        settle();

        // Zero dwell acts as one tick. Fill every row, then scan across
        // several row pairs with writes mixed in. One command midway waits
        // for the output side to drain first.
        write_dwell(16'd0);
        for (int r = 0; r < PANEL_ROWS; r++)
            cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_ROW_WRITE, r, 0, 7, 0,
                                           {$urandom, $urandom}));
        queue_random(500, 85);
        c = random_cmd(85);
        c.hold_for_drain = 1'b1;
        cmd_backlog.insert(300, c);
        settle();

        // Longest dwell: shift one row pair out and stay lit well into the
        // dwell, then cut the dwell below the ticks already lit.
        write_dwell(16'hFFFF);
        for (int n = 0; n < 150; n++)
            cmd_backlog.push_back(make_cmd(rmfb_pkg::MODE_SCAN_TICK, 0, 0, 0, 0, '0));
        settle();

        write_dwell(16'd3);
        queue_random(200, 70);
        settle();

        write_dwell(16'd1);
        queue_random(100, 75);
        settle();

        write_dwell(rmfb_pkg::DWELL_RESET);
        queue_random(200, 60);
        c = random_cmd(100);
        c.hold_for_drain = 1'b1;
        cmd_backlog.insert(120, c);
        settle();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
